[src/hsv_to_rgb565_defines.svh]
// assertion macros shared by the rtl files
`ifndef HSV_TO_RGB565_DEFINES_SVH
`define HSV_TO_RGB565_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define H2R_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define H2R_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/h2r_pkg.sv]
package h2r_pkg;

	// hue sector, one per sixth of the color wheel
	typedef enum logic [2:0] {
		SEC_0 = 3'd0,
		SEC_1 = 3'd1,
		SEC_2 = 3'd2,
		SEC_3 = 3'd3,
		SEC_4 = 3'd4,
		SEC_5 = 3'd5
	} sector_t;

	localparam int unsigned SectorSize = 43;
	localparam logic [7:0] FULL = 8'd255;

	// hue at which each sector starts
	localparam logic [7:0] SEC1_BASE = 8'(SectorSize * 1);
	localparam logic [7:0] SEC2_BASE = 8'(SectorSize * 2);
	localparam logic [7:0] SEC3_BASE = 8'(SectorSize * 3);
	localparam logic [7:0] SEC4_BASE = 8'(SectorSize * 4);
	localparam logic [7:0] SEC5_BASE = 8'(SectorSize * 5);

	// 8 bit to 5 and 6 bit rescale constants
	localparam logic [7:0]  RB_MUL = 8'd249;
	localparam logic [15:0] RB_ADD = 16'd1014;
	localparam logic [7:0]  G_MUL  = 8'd253;
	localparam logic [15:0] G_ADD  = 16'd505;

	// largest fraction seen in the top sector
	localparam logic [7:0] TOP_FRAC_MAX = 8'd240;

endpackage

[src/hsv_to_rgb565.sv]
// HSV to RGB565 converter. Each input word carries an 8-bit hue, saturation and
// brightness; each output word is one packed RGB565 pixel (red 15:11, green 10:5,
// blue 4:0), one pixel per input word, in order. The datapath is a four-stage
// pipeline: sector split, first products, second products, then channel select
// and rescale to 5/6 bits. An accepted word passes through the stage 1 to 4
// registers in order, and out_valid is the stage 4 valid. A new word
// is taken every cycle while out_ready is high; each stage holds its word when the
// stage after it is full and stalled, so nothing is lost or repeated. Zero
// saturation gives a grey with all channels equal to brightness.
`include "hsv_to_rgb565_defines.svh"

module hsv_to_rgb565 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  hue,
	input  logic [7:0]  saturation,
	input  logic [7:0]  brightness,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] pixel
);

	// stage valids and load enables
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic adv_s1, adv_s2, adv_s3, adv_s4;

	assign adv_s4   = !valid_s4 || out_ready;
	assign adv_s3   = !valid_s3 || adv_s4;
	assign adv_s2   = !valid_s2 || adv_s3;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	// stage 1: sector and fraction
	h2r_pkg::sector_t sector_in;
	logic [7:0]       base_in;
	logic [5:0]       rem_in;
	logic [7:0]       frac_in;
	logic [7:0]       rem_full;

	always_comb begin
		if (hue >= h2r_pkg::SEC5_BASE) begin
			sector_in = h2r_pkg::SEC_5;
		end else if (hue >= h2r_pkg::SEC4_BASE) begin
			sector_in = h2r_pkg::SEC_4;
		end else if (hue >= h2r_pkg::SEC3_BASE) begin
			sector_in = h2r_pkg::SEC_3;
		end else if (hue >= h2r_pkg::SEC2_BASE) begin
			sector_in = h2r_pkg::SEC_2;
		end else if (hue >= h2r_pkg::SEC1_BASE) begin
			sector_in = h2r_pkg::SEC_1;
		end else begin
			sector_in = h2r_pkg::SEC_0;
		end
	end

	always_comb begin
		unique case (sector_in)
			h2r_pkg::SEC_1: base_in = h2r_pkg::SEC1_BASE;
			h2r_pkg::SEC_2: base_in = h2r_pkg::SEC2_BASE;
			h2r_pkg::SEC_3: base_in = h2r_pkg::SEC3_BASE;
			h2r_pkg::SEC_4: base_in = h2r_pkg::SEC4_BASE;
			h2r_pkg::SEC_5: base_in = h2r_pkg::SEC5_BASE;
			default:        base_in = 8'd0;
		endcase
	end

	// remainder is below 43 in every sector, times six stays within 8 bits
	assign rem_full = hue - base_in;
	assign rem_in   = rem_full[5:0];
	assign frac_in  = {rem_in, 2'b00} + {1'b0, rem_in, 1'b0};

	h2r_pkg::sector_t sector_s1;
	logic [7:0]       frac_s1, sat_s1, bri_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			sector_s1 <= sector_in;
			frac_s1   <= frac_in;
			sat_s1    <= saturation;
			bri_s1    <= brightness;
		end
	end

	// stage 2: saturation products and p
	logic [15:0] sf_prod, sfc_prod, p_prod;

	assign sf_prod  = 16'(sat_s1) * 16'(frac_s1);
	assign sfc_prod = 16'(sat_s1) * 16'(h2r_pkg::FULL - frac_s1);
	assign p_prod   = 16'(bri_s1) * 16'(h2r_pkg::FULL - sat_s1);

	h2r_pkg::sector_t sector_s2;
	logic [7:0]       sf_s2, sfc_s2, p_s2, bri_s2;
	logic             gray_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			sector_s2 <= sector_s1;
			sf_s2     <= sf_prod[15:8];
			sfc_s2    <= sfc_prod[15:8];
			p_s2      <= p_prod[15:8];
			bri_s2    <= bri_s1;
			gray_s2   <= (sat_s1 == 8'd0);
		end
	end

	// stage 3: q and t
	logic [15:0] q_prod, t_prod;

	assign q_prod = 16'(bri_s2) * 16'(h2r_pkg::FULL - sf_s2);
	assign t_prod = 16'(bri_s2) * 16'(h2r_pkg::FULL - sfc_s2);

	h2r_pkg::sector_t sector_s3;
	logic [7:0]       p_s3, q_s3, t_s3, bri_s3;
	logic             gray_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && valid_s2) begin
			sector_s3 <= sector_s2;
			p_s3      <= p_s2;
			q_s3      <= q_prod[15:8];
			t_s3      <= t_prod[15:8];
			bri_s3    <= bri_s2;
			gray_s3   <= gray_s2;
		end
	end

	// stage 4: channel order, grey bypass, rescale and pack
	logic [7:0]  red, green, blue;
	logic [15:0] red_scaled, green_scaled, blue_scaled;

	always_comb begin
		if (gray_s3) begin
			red   = bri_s3;
			green = bri_s3;
			blue  = bri_s3;
		end else begin
			unique case (sector_s3)
				h2r_pkg::SEC_0: begin
					red = bri_s3; green = t_s3;   blue = p_s3;
				end
				h2r_pkg::SEC_1: begin
					red = q_s3;   green = bri_s3; blue = p_s3;
				end
				h2r_pkg::SEC_2: begin
					red = p_s3;   green = bri_s3; blue = t_s3;
				end
				h2r_pkg::SEC_3: begin
					red = p_s3;   green = q_s3;   blue = bri_s3;
				end
				h2r_pkg::SEC_4: begin
					red = t_s3;   green = p_s3;   blue = bri_s3;
				end
				default: begin
					red = bri_s3; green = p_s3;   blue = q_s3;
				end
			endcase
		end
	end

	// sums stay below 65536 for all 8-bit channels
	assign red_scaled   = 16'(red) * 16'(h2r_pkg::RB_MUL) + h2r_pkg::RB_ADD;
	assign green_scaled = 16'(green) * 16'(h2r_pkg::G_MUL) + h2r_pkg::G_ADD;
	assign blue_scaled  = 16'(blue) * 16'(h2r_pkg::RB_MUL) + h2r_pkg::RB_ADD;

	logic [15:0] pixel_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv_s4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s4 && valid_s3) begin
			pixel_s4 <= {red_scaled[15:11], green_scaled[15:10], blue_scaled[15:11]};
		end
	end

	assign out_valid = valid_s4;
	assign pixel     = pixel_s4;

	// a ready sink lets the whole pipeline advance
	`H2R_ASSERT_SAME(a_ready_chain, out_ready, in_ready, "in_ready low while out_ready high")
	// top sector fraction never exceeds its bound
	`H2R_ASSERT_SAME(a_top_frac, valid_s1 && sector_s1 == h2r_pkg::SEC_5,
		frac_s1 <= h2r_pkg::TOP_FRAC_MAX, "top sector fraction out of range")
	// a stalled word in stage 2 is kept
	`H2R_ASSERT_NEXT(a_hold_s2, valid_s2 && !adv_s3, valid_s2, "stage 2 word dropped on stall")
	// intermediates never exceed brightness
	`H2R_ASSERT_SAME(a_qt_bound, valid_s3,
		q_s3 <= bri_s3 && t_s3 <= bri_s3 && p_s3 <= bri_s3, "intermediate above brightness")

endmodule

[test/hsv_to_rgb565_tb.sv]
`timescale 1ns / 1ps

module hsv_to_rgb565_tb;

	localparam int unsigned WORD_COUNT  = 1450;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned FLUSH_WAIT  = 12;

	typedef struct {
		logic [7:0] hue;
		logic [7:0] saturation;
		logic [7:0] brightness;
		bit         drain_first;
	} hsv_word_t;

	typedef struct {
		logic [7:0]  hue;
		logic [7:0]  saturation;
		logic [7:0]  brightness;
		logic [15:0] pixel;
	} pixel_exp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  hue = 8'd0;
	logic [7:0]  saturation = 8'd0;
	logic [7:0]  brightness = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] pixel;

	hsv_word_t   hsv_words[$];
	pixel_exp_t  pixels_due[$];
	bit          word_taken = 1'b0;
	int unsigned words_in = 0;
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;

	hsv_to_rgb565 dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.hue(hue),
		.saturation(saturation),
		.brightness(brightness),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pixel(pixel)
	);

	always #5 clk = ~clk;

	// 8 bit channel down to 5 bits, rounded
	function automatic logic [4:0] to_five_bits(int unsigned x);
		return 5'((x * h2r_pkg::RB_MUL + h2r_pkg::RB_ADD) >> 11);
	endfunction

	// expected rgb565 pixel for one hsv triple
	function automatic logic [15:0] hsv_pixel(logic [7:0] h, logic [7:0] s, logic [7:0] v);
		int unsigned hv, sv, vv, frac, p, q, t, r, g, b;
		h2r_pkg::sector_t sec;
		hv = h;
		sv = s;
		vv = v;
		if (sv == 0) begin
			r = vv;
			g = vv;
			b = vv;
		end else begin
			sec = h2r_pkg::sector_t'(hv / h2r_pkg::SectorSize);
			frac = ((hv - int'(sec) * h2r_pkg::SectorSize) * 6) & 8'hFF;
			p = ((vv * (h2r_pkg::FULL - sv)) >> 8) & 8'hFF;
			q = ((vv * (h2r_pkg::FULL - ((sv * frac) >> 8))) >> 8) & 8'hFF;
			t = ((vv * (h2r_pkg::FULL - ((sv * (h2r_pkg::FULL - frac)) >> 8))) >> 8) & 8'hFF;
			case (sec)
				h2r_pkg::SEC_0: begin r = vv; g = t;  b = p;  end
				h2r_pkg::SEC_1: begin r = q;  g = vv; b = p;  end
				h2r_pkg::SEC_2: begin r = p;  g = vv; b = t;  end
				h2r_pkg::SEC_3: begin r = p;  g = q;  b = vv; end
				h2r_pkg::SEC_4: begin r = t;  g = p;  b = vv; end
				default: begin r = vv; g = p;  b = q;  end
			endcase
		end
		return {to_five_bits(r), 6'((g * h2r_pkg::G_MUL + h2r_pkg::G_ADD) >> 10),
			to_five_bits(b)};
	endfunction

	task automatic add_word(logic [7:0] h, logic [7:0] s, logic [7:0] v, bit drain = 1'b0);
		hsv_word_t w;
		w.hue = h;
		w.saturation = s;
		w.brightness = v;
		w.drain_first = drain;
		hsv_words.push_back(w);
	endtask

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	// idle percentages for the current phase of the run
	function automatic int unsigned sender_idle_pct();
		if (words_in < WORD_COUNT / 3)
			return 10;
		else if (words_in < 2 * WORD_COUNT / 3)
			return 48;
		return 0;
	endfunction

	function automatic int unsigned receiver_idle_pct();
		if (words_in < WORD_COUNT / 3)
			return 48;
		else if (words_in < 2 * WORD_COUNT / 3)
			return 10;
		return 0;
	endfunction

	// input driver, changes at the falling edge
	always @(negedge clk) begin
		bit next_valid;
		if (arst_n) begin
			next_valid = in_valid;
			if (in_valid && word_taken) begin
				void'(hsv_words.pop_front());
				next_valid = 1'b0;
			end
			if (!next_valid && hsv_words.size() > 0) begin
				// a drain word waits until every pixel is back
				if (!(hsv_words[0].drain_first && pixels_due.size() > 0) &&
						$urandom_range(99) >= sender_idle_pct()) begin
					next_valid = 1'b1;
					hue <= hsv_words[0].hue;
					saturation <= hsv_words[0].saturation;
					brightness <= hsv_words[0].brightness;
				end
			end
			in_valid <= next_valid;
			out_ready <= ($urandom_range(99) >= receiver_idle_pct());
		end
	end

	// monitor and scoreboard, sampled at the rising edge
	always @(posedge clk) begin
		pixel_exp_t exp_word;
		pixel_exp_t got_word;
		bit out_taken;
		word_taken = in_valid && in_ready;
		out_taken = out_valid && out_ready;
		if (arst_n) begin
			// check output word before queuing the new one
			if (out_taken) begin
				if (pixels_due.size() == 0) begin
					report_mismatch($sformatf("unexpected pixel %h", pixel));
				end else begin
					exp_word = pixels_due.pop_front();
					if (pixel !== exp_word.pixel)
						report_mismatch($sformatf("h=%0d s=%0d v=%0d pixel %h expected %h",
							exp_word.hue, exp_word.saturation, exp_word.brightness,
							pixel, exp_word.pixel));
				end
			end
			if (word_taken) begin
				got_word.hue = hue;
				got_word.saturation = saturation;
				got_word.brightness = brightness;
				got_word.pixel = hsv_pixel(hue, saturation, brightness);
				pixels_due.push_back(got_word);
				words_in++;
			end
			// watchdog on cycles with no traffic at all
			if (word_taken || out_taken)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", STALL_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		int unsigned pick;
		logic [7:0] h, s, v;

		// grey: zero saturation, brightness at both extremes and midscale
		add_word(8'd0, 8'd0, 8'd0);
		add_word(8'd255, 8'd0, 8'd255);
		add_word(8'd100, 8'd0, 8'd128);
		// sector edges at full saturation and brightness
		add_word(8'd0, 8'd255, 8'd255);
		add_word(8'd42, 8'd255, 8'd255);
		add_word(8'd43, 8'd255, 8'd255);
		add_word(8'd85, 8'd255, 8'd255);
		add_word(8'd86, 8'd255, 8'd255);
		add_word(8'd128, 8'd255, 8'd255);
		add_word(8'd129, 8'd255, 8'd255);
		add_word(8'd171, 8'd255, 8'd255);
		add_word(8'd172, 8'd255, 8'd255);
		add_word(8'd214, 8'd255, 8'd255);
		// top sector, up to its largest fraction
		add_word(8'd215, 8'd255, 8'd255);
		add_word(8'd255, 8'd255, 8'd255);
		add_word(8'd255, 8'd128, 8'd200);
		// minimal nonzero saturation and brightness, zero brightness, and a drain word
		add_word(8'd30, 8'd1, 8'd255);
		add_word(8'd200, 8'd255, 8'd1);
		add_word(8'd150, 8'd1, 8'd1);
		add_word(8'd60, 8'd255, 8'd0);
		add_word(8'd170, 8'd170, 8'd85, 1'b1);
		add_word(8'd85, 8'd85, 8'd170);

		// random words, biased toward saturation and brightness extremes and the top hue sector
		while (hsv_words.size() < WORD_COUNT) begin
			h = 8'($urandom);
			s = 8'($urandom);
			v = 8'($urandom);
			pick = $urandom_range(99);
			if (pick < 12)
				s = 8'd0;
			else if (pick < 24)
				s = 8'd255;
			else if (pick < 32)
				v = 8'd255;
			else if (pick < 36)
				v = 8'd0;
			else if (pick < 44)
				h = 8'($urandom_range(255, 215));
			add_word(h, s, v, (hsv_words.size() % 300) == 150);
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (hsv_words.size() > 0 || in_valid)
			@(posedge clk);
		while (pixels_due.size() > 0)
			@(posedge clk);
		repeat (FLUSH_WAIT) @(posedge clk);

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
